// ===== rtl/manchester_pulse_width_decoder_assert.svh =====
// Assertion macros for the Manchester pulse-width decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MANCHESTER_PULSE_WIDTH_DECODER_ASSERT_SVH
`define MANCHESTER_PULSE_WIDTH_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define MPWD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mpwd assertion failed");

// Check that a condition never occurs outside reset.
`define MPWD_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mpwd forbidden condition seen");

`else

`define MPWD_ASSERT(label, clk, rst_n, prop)

`define MPWD_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== rtl/mpwd_pkg.sv =====
// Shared types, constants and decode table for the Manchester pulse-width decoder.
// No dependencies; used by every other RTL file of the block except the assertion header.
`timescale 1ns / 1ps

package mpwd_pkg;

    localparam int FRAME_BITS_DEF = 32;
    localparam int WIDTH_W        = 16;
    localparam int WORD_W         = 32;
    localparam int CFG_INDEX_W    = 2;

    localparam int HALF_BIT_TICKS  = 900;
    localparam int TOLERANCE_TICKS = 270;

    localparam logic [WIDTH_W-1:0] MIN_ONE_RST = WIDTH_W'(HALF_BIT_TICKS - TOLERANCE_TICKS);
    localparam logic [WIDTH_W-1:0] MAX_ONE_RST = WIDTH_W'(HALF_BIT_TICKS + TOLERANCE_TICKS);
    localparam logic [WIDTH_W-1:0] MIN_TWO_RST =
        WIDTH_W'(2 * HALF_BIT_TICKS - TOLERANCE_TICKS);
    localparam logic [WIDTH_W-1:0] MAX_TWO_RST =
        WIDTH_W'(2 * HALF_BIT_TICKS + TOLERANCE_TICKS);

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_ONE_HALF = 2'd0,
        CFG_MAX_ONE_HALF = 2'd1,
        CFG_MIN_TWO_HALF = 2'd2,
        CFG_MAX_TWO_HALF = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLS_ONE   = 2'd0,
        CLS_TWO   = 2'd1,
        CLS_WRONG = 2'd2
    } pw_class_t;

    typedef enum logic [1:0] {
        ACT_ZERO    = 2'd0,
        ACT_ONE     = 2'd1,
        ACT_NONE    = 2'd2,
        ACT_INVALID = 2'd3
    } act_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] min_one_half;
        logic [WIDTH_W-1:0] max_one_half;
        logic [WIDTH_W-1:0] min_two_half;
        logic [WIDTH_W-1:0] max_two_half;
    } windows_t;

    typedef struct packed {
        logic              frame_valid;
        logic [WORD_W-1:0] frame_word;
        logic              frame_pending;
    } result_t;

    // Edge direction, previous bit and pulse class to action; a wrong width resets the packet.
    function automatic act_t decode_action(input logic rising, input logic prev,
                                           input pw_class_t cls);
        act_t act;
        act = ACT_INVALID;
        unique case (cls)
            CLS_ONE:
            begin
                if (rising)
                    act = prev ? ACT_NONE : ACT_ZERO;
                else
                    act = prev ? ACT_ONE : ACT_NONE;
            end
            CLS_TWO:
            begin
                if (rising)
                    act = prev ? ACT_ZERO : ACT_INVALID;
                else
                    act = prev ? ACT_INVALID : ACT_ONE;
            end
            default:
            begin
                act = ACT_INVALID;
            end
        endcase
        return act;
    endfunction

endpackage

// ===== rtl/mpwd_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on mpwd_pkg for field widths.
`timescale 1ns / 1ps

interface mpwd_req_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [mpwd_pkg::WIDTH_W-1:0]   pulse_width;
    logic                           edge_rising;

    modport source (output valid, req_type, pulse_width, edge_rising, input ready);
    modport sink   (input valid, req_type, pulse_width, edge_rising, output ready);
endinterface

interface mpwd_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           frame_valid;
    logic [mpwd_pkg::WORD_W-1:0]    frame_word;
    logic                           frame_pending;

    modport source (output valid, frame_valid, frame_word, frame_pending, input ready);
    modport sink   (input valid, frame_valid, frame_word, frame_pending, output ready);
endinterface

// ===== rtl/manchester_pulse_width_decoder.sv =====
// Top level of the Manchester pulse-width decoder: channels, registers, config port.
// Depends on mpwd_pkg, mpwd_if, mpwd_classify and mpwd_core.
// Usage:
//   req channel: each item is either an edge sample (req_type 0, with the pulse
//     width in timer ticks and the edge direction) or a read request (req_type 1).
//   rsp channel: exactly one result item per request item, in order. A read of
//     a complete frame returns frame_valid 1 with the word, first bit in the MSB;
//     every other item returns frame_valid 0 and a zero word. frame_pending shows
//     whether a frame waits to be read after the item.
//   cfg port: write cfg_data to window register cfg_index while cfg_we is high;
//     write only while no item is in flight.
// Path: an accepted item lands in the input register, is decoded when it advances
//   and is captured in the result register, which drives rsp.
// Throughput: one item per cycle while rsp takes its results; the single decode pass
//   between the input register and the result register sets that figure.
// Reset: rst_n clears the valid flags of both pipeline registers, restores the default
//   windows (630/1170/1530/2070 ticks) and restarts the packet, waiting for sync.
// Stall: when rsp is not taken the result register holds, the input register
//   holds its item and req.ready drops once both are full.
`timescale 1ns / 1ps

module manchester_pulse_width_decoder
#(
    parameter int FRAME_BITS = mpwd_pkg::FRAME_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    mpwd_req_if.sink                           req,
    mpwd_rsp_if.source                         rsp,
    input  logic                               cfg_we,
    input  logic [mpwd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mpwd_pkg::WIDTH_W-1:0]       cfg_data
);

    // Input register
    logic                           in_valid_reg;
    logic                           req_type_reg;
    logic [mpwd_pkg::WIDTH_W-1:0]   pulse_width_reg;
    logic                           edge_rising_reg;

    // Result register
    logic                           out_valid_reg;
    mpwd_pkg::result_t              result_reg;

    // Window registers
    mpwd_pkg::windows_t             win_reg;

    logic                           advance;
    logic                           in_take;
    mpwd_pkg::pw_class_t            cls;
    mpwd_pkg::result_t              result_next;

    // Advance the held item whenever the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.frame_valid   = result_reg.frame_valid;
    assign rsp.frame_word    = result_reg.frame_word;
    assign rsp.frame_pending = result_reg.frame_pending;

    mpwd_classify u_classify
    (
        .win         (win_reg),
        .pulse_width (pulse_width_reg),
        .cls         (cls)
    );

    mpwd_core #(.FRAME_BITS(FRAME_BITS)) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .req_type    (req_type_reg),
        .edge_rising (edge_rising_reg),
        .cls         (cls),
        .result_next (result_next)
    );

    // Valid flags: drop on drain, set on fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: capture a new item, hold it while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_type_reg    <= req.req_type;
            pulse_width_reg <= req.pulse_width;
            edge_rising_reg <= req.edge_rising;
        end
        if (advance)
            result_reg <= result_next;
    end

    // Window registers with their default tolerances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.min_one_half <= mpwd_pkg::MIN_ONE_RST;
            win_reg.max_one_half <= mpwd_pkg::MAX_ONE_RST;
            win_reg.min_two_half <= mpwd_pkg::MIN_TWO_RST;
            win_reg.max_two_half <= mpwd_pkg::MAX_TWO_RST;
        end
        else if (cfg_we)
        begin
            unique case (mpwd_pkg::cfg_reg_t'(cfg_index))
                mpwd_pkg::CFG_MIN_ONE_HALF: win_reg.min_one_half <= cfg_data;
                mpwd_pkg::CFG_MAX_ONE_HALF: win_reg.max_one_half <= cfg_data;
                mpwd_pkg::CFG_MIN_TWO_HALF: win_reg.min_two_half <= cfg_data;
                mpwd_pkg::CFG_MAX_TWO_HALF: win_reg.max_two_half <= cfg_data;
            endcase
        end
    end

endmodule

// ===== rtl/mpwd_classify.sv =====
// Pulse width classifier: 1T, 2T or wrong against exclusive window bounds.
// Depends on mpwd_pkg.
`timescale 1ns / 1ps

module mpwd_classify
(
    input  mpwd_pkg::windows_t               win,
    input  logic [mpwd_pkg::WIDTH_W-1:0]     pulse_width,
    output mpwd_pkg::pw_class_t              cls
);

    logic in_one;
    logic in_two;

    assign in_one = (pulse_width > win.min_one_half) && (pulse_width < win.max_one_half);
    assign in_two = (pulse_width > win.min_two_half) && (pulse_width < win.max_two_half);

    // 1T window wins when the windows overlap
    always_comb
    begin
        priority if (in_one)
            cls = mpwd_pkg::CLS_ONE;
        else if (in_two)
            cls = mpwd_pkg::CLS_TWO;
        else
            cls = mpwd_pkg::CLS_WRONG;
    end

endmodule

// ===== rtl/mpwd_core.sv =====
// Decoder state: shift word, bit counter, previous bit, sync and ready flags.
// Depends on mpwd_pkg and manchester_pulse_width_decoder_assert.svh.
`timescale 1ns / 1ps
`include "manchester_pulse_width_decoder_assert.svh"

module mpwd_core
#(
    parameter int FRAME_BITS = mpwd_pkg::FRAME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  req_type,
    input  logic                  edge_rising,
    input  mpwd_pkg::pw_class_t   cls,
    output mpwd_pkg::result_t     result_next
);

    localparam int CNT_W = $clog2(FRAME_BITS);
    localparam logic [CNT_W-1:0] BITS_LEFT_RST = CNT_W'(FRAME_BITS - 1);

    logic [mpwd_pkg::WORD_W-1:0] shift_word_reg, shift_word_next;
    logic [CNT_W-1:0]            bits_left_reg, bits_left_next;
    logic                        previous_bit_reg, previous_bit_next;
    logic                        awaiting_sync_reg, awaiting_sync_next;
    logic                        frame_ready_reg, frame_ready_next;

    logic                        packet_reset;
    logic                        new_bit;
    logic [mpwd_pkg::WORD_W-1:0] merged_word;
    mpwd_pkg::act_t              act;

    assign act         = mpwd_pkg::decode_action(edge_rising, previous_bit_reg, cls);
    assign new_bit     = (act == mpwd_pkg::ACT_ONE);
    assign merged_word = shift_word_reg | mpwd_pkg::WORD_W'(new_bit);

    always_comb
    begin
        shift_word_next    = shift_word_reg;
        bits_left_next     = bits_left_reg;
        previous_bit_next  = previous_bit_reg;
        awaiting_sync_next = awaiting_sync_reg;
        frame_ready_next   = frame_ready_reg;
        packet_reset       = 1'b0;
        result_next        = '0;

        if (step)
        begin
            if (req_type == mpwd_pkg::REQ_READ)
            begin
                if (frame_ready_reg)
                begin
                    result_next.frame_valid = 1'b1;
                    result_next.frame_word  = shift_word_reg;
                    frame_ready_next        = 1'b0;
                    packet_reset            = 1'b1;
                end
            end
            else if (!frame_ready_reg)
            begin
                if (!edge_rising && awaiting_sync_reg)
                begin
                    awaiting_sync_next = 1'b0;
                end
                else
                begin
                    unique case (act)
                        mpwd_pkg::ACT_NONE:
                        begin
                        end
                        mpwd_pkg::ACT_INVALID:
                        begin
                            packet_reset = 1'b1;
                        end
                        mpwd_pkg::ACT_ZERO, mpwd_pkg::ACT_ONE:
                        begin
                            previous_bit_next = new_bit;
                            if (bits_left_reg != '0)
                            begin
                                shift_word_next = merged_word << 1;
                                bits_left_next  = bits_left_reg - CNT_W'(1);
                            end
                            else
                            begin
                                shift_word_next  = merged_word;
                                frame_ready_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end

        if (packet_reset)
        begin
            shift_word_next    = '0;
            bits_left_next     = BITS_LEFT_RST;
            previous_bit_next  = 1'b1;
            awaiting_sync_next = 1'b1;
        end

        result_next.frame_pending = frame_ready_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_word_reg    <= '0;
            bits_left_reg     <= BITS_LEFT_RST;
            previous_bit_reg  <= 1'b1;
            awaiting_sync_reg <= 1'b1;
            frame_ready_reg   <= 1'b0;
        end
        else
        begin
            shift_word_reg    <= shift_word_next;
            bits_left_reg     <= bits_left_next;
            previous_bit_reg  <= previous_bit_next;
            awaiting_sync_reg <= awaiting_sync_next;
            frame_ready_reg   <= frame_ready_next;
        end
    end

    // Edges leave a waiting frame untouched
    `MPWD_ASSERT(a_frame_held, clk, rst_n,
        (step && frame_ready_reg && req_type == mpwd_pkg::REQ_EDGE) |=>
        (shift_word_reg == $past(shift_word_reg)) && frame_ready_reg)
    // A frame completes only on the last bit
    `MPWD_ASSERT(a_ready_on_last_bit, clk, rst_n,
        $rose(frame_ready_reg) |-> ($past(bits_left_reg) == '0))
    // Releasing a frame restarts the packet
    `MPWD_ASSERT(a_release_resets, clk, rst_n,
        (step && frame_ready_reg && req_type == mpwd_pkg::REQ_READ) |=>
        (!frame_ready_reg && awaiting_sync_reg && shift_word_reg == '0))

endmodule
